// File: hdl/gwr_pkg.sv
// Shared constants and types for the grid wave reachability block.
`timescale 1ns / 1ps
`default_nettype none
package gwr_pkg;

  // Grid side length; the map is GRID_DIM x GRID_DIM cells.
  localparam int GRID_DIM = 16;
  // Width of the row and column fields on the input channel.
  localparam int FIELD_W  = 4;
  // Bits needed to index one row or one column inside the grid.
  localparam int IDX_W    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;

  // Operation codes carried by in_operation.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [GRID_DIM-1:0] row_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // Control broadcast from the sequencer to every row cell.
  typedef struct packed {
    logic seed;   // start a new wave: clear, then mark the start cell
    logic step;   // advance the wave by one generation
    logic wr;     // write one occupancy bit
    logic occ;    // value written
    idx_t col;    // column of the write or of the start cell
  } gwr_ctrl_t;

endpackage : gwr_pkg
`default_nettype wire

// File: hdl/gwr_row_cell.sv
// One grid row: occupancy, reached and frontier bits and the wave step for that row.
`timescale 1ns / 1ps
`default_nettype none
module gwr_row_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gwr_pkg::gwr_ctrl_t ctrl,
  input  wire logic              row_sel,
  input  wire gwr_pkg::row_t     front_up,
  input  wire gwr_pkg::row_t     front_dn,
  output gwr_pkg::row_t          front_row,
  output gwr_pkg::row_t          reached_row,
  output gwr_pkg::row_t          occ_row,
  output logic                   live
);
  import gwr_pkg::*;

  row_t occ_r, occ_nxt;
  row_t reached_r, reached_nxt;
  row_t front_r, front_nxt;
  row_t spread;
  row_t start_mask;

  // New cells: free, not yet reached, next to a frontier cell of this row or a neighbor row.
  assign spread     = ~occ_r & ~reached_r &
                      (front_up | front_dn | (front_r << 1) | (front_r >> 1));
  assign start_mask = row_sel ? (row_t'(1) << ctrl.col) : '0;

  always_comb begin
    occ_nxt     = occ_r;
    reached_nxt = reached_r;
    front_nxt   = front_r;
    if (ctrl.wr && row_sel) begin
      occ_nxt[ctrl.col] = ctrl.occ;
    end
    if (ctrl.seed) begin
      reached_nxt = start_mask;
      front_nxt   = start_mask;
    end else if (ctrl.step) begin
      reached_nxt = reached_r | spread;
      front_nxt   = spread;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      reached_r <= '0;
      front_r   <= '0;
    end else begin
      occ_r     <= occ_nxt;
      reached_r <= reached_nxt;
      front_r   <= front_nxt;
    end
  end

  assign front_row   = front_r;
  assign reached_row = reached_r;
  assign occ_row     = occ_r;
  assign live        = |front_r;

endmodule : gwr_row_cell
`default_nettype wire

// File: hdl/grid_wave_reachability.sv
// Top level: sequencer, result register and the chain of row cells of the wave engine.
//
// Input channel (in_valid/in_ready) carries one item: a write (in_operation = 0)
// sets the occupancy bit of cell (in_cell_row, in_cell_col); a query (= 1) asks
// whether a 4-neighbor wave from that cell reaches (in_target_row, in_target_col).
// Writes give no result; writes outside the grid are dropped.
// A query gives one result item on out_valid/out_ready: out_reachable and
// out_target_blocked (a blocked target or target == start reports reachable).
// The grid is a chain of GRID_DIM row cells; each row swaps its frontier with
// the rows above and below every cycle, so one wave generation costs one cycle.
// A query's result goes valid once the wave hits the target or the frontier
// empties. The next item is taken once that result is loaded, which waits
// while a stalled receiver still holds the previous result.
// One item is processed at a time; in_ready is high whenever no wave is running,
// also while a result still waits in the output register.
// If the receiver stalls, a finished wave holds its state until the output
// register frees up. Reset clears the occupancy map to all free and empties
// the wave state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module grid_wave_reachability (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_operation,
  input  wire logic [gwr_pkg::FIELD_W-1:0] in_cell_row,
  input  wire logic [gwr_pkg::FIELD_W-1:0] in_cell_col,
  input  wire logic                      in_occupied,
  input  wire logic [gwr_pkg::FIELD_W-1:0] in_target_row,
  input  wire logic [gwr_pkg::FIELD_W-1:0] in_target_col,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_reachable,
  output logic                           out_target_blocked
);
  import gwr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAVE = 2'b10
  } state_t;

  state_t st_r, st_nxt;

  // Query context, captured at accept
  idx_t tr_r, tc_r;
  logic tgt_in_r, same_r;
  // Result register
  logic out_valid_r, out_valid_nxt;
  logic reach_r, blk_r;

  logic      accept, is_query, start_in, tgt_in, same;
  idx_t      start_row;
  gwr_ctrl_t ctrl;
  row_t      front_rows   [GRID_DIM];
  row_t      reached_rows [GRID_DIM];
  row_t      occ_rows     [GRID_DIM];
  logic [GRID_DIM-1:0] live_vec;
  logic      hit, tgt_occ, any_live, done, slot_free, finish;

  assign in_ready  = (st_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_query  = (in_operation == OP_QUERY);
  assign start_in  = (int'(in_cell_row) < GRID_DIM) && (int'(in_cell_col) < GRID_DIM);
  assign tgt_in    = (int'(in_target_row) < GRID_DIM) && (int'(in_target_col) < GRID_DIM);
  assign same      = (in_cell_row == in_target_row) && (in_cell_col == in_target_col);
  assign start_row = idx_t'(in_cell_row);

  // Done when target is outside the grid, already reached, or the frontier is empty.
  assign hit       = reached_rows[tr_r][tc_r];
  assign tgt_occ   = occ_rows[tr_r][tc_r];
  assign any_live  = |live_vec;
  assign done      = !tgt_in_r || hit || !any_live;
  assign slot_free = !out_valid_r || out_ready;
  assign finish    = (st_r == ST_WAVE) && done && slot_free;

  always_comb begin
    ctrl.seed = accept && is_query;
    ctrl.wr   = accept && !is_query && start_in;
    ctrl.occ  = in_occupied;
    ctrl.col  = idx_t'(in_cell_col);
    // Freeze the wave once done so a stalled result stays consistent.
    ctrl.step = (st_r == ST_WAVE) && !done;
  end

  // Chain of row cells, each wired to its upper and lower neighbor.
  for (genvar r = 0; r < GRID_DIM; r++) begin : g_row
    row_t up, dn;
    if (r > 0) begin : g_up
      assign up = front_rows[r-1];
    end else begin : g_up_edge
      assign up = '0;
    end
    if (r < GRID_DIM - 1) begin : g_dn
      assign dn = front_rows[r+1];
    end else begin : g_dn_edge
      assign dn = '0;
    end

    gwr_row_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .row_sel     (start_in && (start_row == idx_t'(r))),
      .front_up    (up),
      .front_dn    (dn),
      .front_row   (front_rows[r]),
      .reached_row (reached_rows[r]),
      .occ_row     (occ_rows[r]),
      .live        (live_vec[r])
    );
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept && is_query) st_nxt = ST_WAVE;
      end
      ST_WAVE: begin
        if (finish) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      tr_r     <= idx_t'(in_target_row);
      tc_r     <= idx_t'(in_target_col);
      tgt_in_r <= tgt_in;
      same_r   <= same;
    end
    if (finish) begin
      reach_r <= tgt_in_r && (same_r || tgt_occ || hit);
      blk_r   <= tgt_in_r && tgt_occ;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reachable      = reach_r;
  assign out_target_blocked = blk_r;

  // A query always starts a wave in the next cycle.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_query |=> st_r == ST_WAVE)
    else $error("query accept did not start a wave");

  // A write never produces a result item.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_query && !out_valid_r |=> !out_valid_r)
    else $error("write produced a result");

  // A finished wave loads the result register.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && st_r == ST_IDLE)
    else $error("finished wave did not present a result");

  // Every frontier cell is also marked reached.
  for (genvar r = 0; r < GRID_DIM; r++) begin : g_chk
    a_front_reached: assert property (@(posedge clk) disable iff (!rst_n)
      (front_rows[r] & ~reached_rows[r]) == '0)
      else $error("frontier cell not marked reached");
  end

endmodule : grid_wave_reachability
`default_nettype wire

// File: bench/tb_grid_wave_reachability.sv
// Self-checking testbench for grid_wave_reachability: directed paths, mazes, random traffic.
`timescale 1ns / 1ps
module tb_grid_wave_reachability;
  import gwr_pkg::*;

  // Run guard; far above the slowest legal run (every query a full-grid wave).
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Drain margin, sized to cover the longest possible wave.
  localparam int DRAIN_CYCLES = GRID_DIM * GRID_DIM + 40;

  typedef logic [FIELD_W-1:0] coord_t;

  // One expected answer of a query.
  typedef struct packed {
    logic reachable;
    logic target_blocked;
  } path_verdict_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_operation = OP_WRITE;
  coord_t in_cell_row = '0;
  coord_t in_cell_col = '0;
  logic   in_occupied = 1'b0;
  coord_t in_target_row = '0;
  coord_t in_target_col = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_reachable;
  logic   out_target_blocked;

  // Shadow occupancy map: bit c of occ_grid[r] is cell (r, c), 1 = blocked.
  logic [GRID_DIM-1:0] occ_grid [GRID_DIM];
  // Answers owed by the block, oldest first.
  path_verdict_t       verdict_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  grid_wave_reachability uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_occupied        (in_occupied),
    .in_target_row      (in_target_row),
    .in_target_col      (in_target_col),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reachable      (out_reachable),
    .out_target_blocked (out_target_blocked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random back-pressure at the current phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ------------------------------------------------------------------
  // Predictor: row-parallel breadth-first wave over the shadow map.
  // The start is reached even if blocked; a generation takes free,
  // unreached cells with a 4-neighbor in the current frontier. The wave
  // stops on hitting the target or when a generation adds nothing.
  // ------------------------------------------------------------------
  function automatic path_verdict_t predict_path(int sr, int sc, int tr, int tc);
    logic [GRID_DIM-1:0] reached [GRID_DIM];
    logic [GRID_DIM-1:0] front   [GRID_DIM];
    logic [GRID_DIM-1:0] grown   [GRID_DIM];
    logic [GRID_DIM-1:0] nbr;
    logic                grew;
    path_verdict_t       verdict;
    for (int r = 0; r < GRID_DIM; r++) begin
      reached[r] = '0;
      front[r]   = '0;
    end
    // Target off the grid: nothing to report.
    if (tr >= GRID_DIM || tc >= GRID_DIM) begin
      verdict = '0;
      return verdict;
    end
    // Start off the grid seeds nothing.
    if (sr < GRID_DIM && sc < GRID_DIM) begin
      reached[sr][sc] = 1'b1;
      front[sr][sc]   = 1'b1;
      grew = 1'b1;
      while (!reached[tr][tc] && grew) begin
        grew = 1'b0;
        for (int r = 0; r < GRID_DIM; r++) begin
          nbr = (front[r] << 1) | (front[r] >> 1);
          if (r > 0)            nbr |= front[r-1];
          if (r < GRID_DIM - 1) nbr |= front[r+1];
          grown[r] = nbr & ~occ_grid[r] & ~reached[r];
          if (grown[r] != '0) grew = 1'b1;
        end
        for (int r = 0; r < GRID_DIM; r++) begin
          front[r]    = grown[r];
          reached[r] |= grown[r];
        end
      end
    end
    // Blocked target and target == start both report reachable.
    verdict.target_blocked = occ_grid[tr][tc];
    verdict.reachable      = (sr == tr && sc == tc) || occ_grid[tr][tc] || reached[tr][tc];
    return verdict;
  endfunction

  // ------------------------------------------------------------------
  // Sender: optional random gap, then hold the item until accepted.
  // in_valid is only lowered when a gap is taken, so a back-to-back
  // item never sees a low and a high in the same step.
  // ------------------------------------------------------------------
  task automatic send_item(logic op, coord_t row, coord_t col, logic occ,
                           coord_t trow, coord_t tcol);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_cell_row   <= row;
    in_cell_col   <= col;
    in_occupied   <= occ;
    in_target_row <= trow;
    in_target_col <= tcol;
    do @(posedge clk); while (!in_ready);
    // Item accepted at this edge: update the shadow state in order.
    if (op == OP_WRITE) begin
      if (row < GRID_DIM && col < GRID_DIM) occ_grid[row][col] = occ;
    end else begin
      verdict_q.push_back(predict_path(int'(row), int'(col), int'(trow), int'(tcol)));
    end
  endtask

  // Unused fields get random values so every input bit toggles.
  task automatic write_cell(int row, int col, logic occ);
    send_item(OP_WRITE, coord_t'(row), coord_t'(col), occ,
              coord_t'($urandom_range(15)), coord_t'($urandom_range(15)));
  endtask

  task automatic query_path(int sr, int sc, int tr, int tc);
    send_item(OP_QUERY, coord_t'(sr), coord_t'(sc), 1'($urandom_range(1)),
              coord_t'(tr), coord_t'(tc));
  endtask

  // Checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    path_verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result item with no query outstanding");
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_reachable !== want.reachable) begin
          $error("reachable: expected %0b, actual %0b", want.reachable, out_reachable);
          mismatch_count++;
        end
        if (out_target_blocked !== want.target_blocked) begin
          $error("target_blocked: expected %0b, actual %0b",
                 want.target_blocked, out_target_blocked);
          mismatch_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Empty map right after reset: corners, same cell, neighbors.
  task automatic test_open_grid();
    query_path(0, 0, GRID_DIM - 1, GRID_DIM - 1);
    query_path(GRID_DIM - 1, GRID_DIM - 1, GRID_DIM - 1, GRID_DIM - 1);
    query_path(3, 4, 3, 5);
    query_path(GRID_DIM - 1, 0, 0, GRID_DIM - 1);
  endtask

  // Blocked target, blocked start, start == target on a blocked cell.
  task automatic test_blocked_cells();
    write_cell(5, 5, 1'b1);
    query_path(0, 0, 5, 5);       // blocked target reports reachable
    query_path(5, 5, 9, 9);       // blocked start still spreads
    query_path(5, 5, 5, 5);       // same cell, blocked
    write_cell(5, 5, 1'b0);
    query_path(5, 5, 5, 5);       // same cell, free again
  endtask

  // Walled-in cell and a walled-in corner.
  task automatic test_enclosure();
    write_cell(9, 10, 1'b1);
    write_cell(11, 10, 1'b1);
    write_cell(10, 9, 1'b1);
    write_cell(10, 11, 1'b1);
    query_path(10, 10, 0, 0);     // cannot get out
    query_path(0, 0, 10, 10);     // cannot get in
    query_path(9, 10, 10, 10);    // blocked start next to the pocket
    write_cell(0, 1, 1'b1);
    write_cell(1, 0, 1'b1);
    query_path(0, 0, GRID_DIM - 1, GRID_DIM - 1);
    write_cell(9, 10, 1'b0);
    write_cell(11, 10, 1'b0);
    write_cell(10, 9, 1'b0);
    write_cell(10, 11, 1'b0);
    write_cell(0, 1, 1'b0);
    write_cell(1, 0, 1'b0);
  endtask

  // Serpentine maze: odd rows walled with the gap at alternating ends,
  // forcing waves that wind back and forth across the grid. Then close the
  // last gap and finally clear the maze.
  task automatic test_long_path();
    int gap_col;
    for (int r = 1; r < GRID_DIM - 1; r += 2) begin
      gap_col = ((r % 4) == 1) ? GRID_DIM - 1 : 0;
      for (int c = 0; c < GRID_DIM; c++)
        if (c != gap_col) write_cell(r, c, 1'b1);
    end
    query_path(0, 0, GRID_DIM - 1, GRID_DIM - 1);
    query_path(GRID_DIM - 1, 0, 0, 0);
    query_path(0, 0, GRID_DIM - 2, 0);
    query_path(0, GRID_DIM - 1, 2, 0);
    write_cell(GRID_DIM - 3, GRID_DIM - 1, 1'b1);
    write_cell(GRID_DIM - 3, 0, 1'b1);
    query_path(0, 0, GRID_DIM - 1, GRID_DIM - 1);   // last wall now solid
    query_path(GRID_DIM - 1, 3, GRID_DIM - 1, 12);
    for (int r = 1; r < GRID_DIM - 1; r += 2)
      for (int c = 0; c < GRID_DIM; c++) write_cell(r, c, 1'b0);
  endtask

  // Random writes and queries; the map drifts toward block_pct density.
  // Now and then a wall with one gap is drawn to shape longer paths.
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items, int block_pct);
    int sr, sc, tr, tc, line, gap;
    logic vertical;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 3) begin
        vertical = 1'($urandom_range(1));
        line     = $urandom_range(GRID_DIM - 1);
        gap      = $urandom_range(GRID_DIM - 1);
        for (int k = 0; k < GRID_DIM; k++)
          if (k != gap) begin
            if (vertical) write_cell(k, line, 1'b1);
            else          write_cell(line, k, 1'b1);
          end
      end else if ($urandom_range(99) < 62) begin
        write_cell($urandom_range(15), $urandom_range(15), $urandom_range(99) < block_pct);
      end else begin
        sr = $urandom_range(15);
        sc = $urandom_range(15);
        if ($urandom_range(99) < 8) begin
          tr = sr;
          tc = sc;
        end else begin
          tr = $urandom_range(15);
          tc = $urandom_range(15);
        end
        query_path(sr, sc, tr, tc);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < GRID_DIM; r++) occ_grid[r] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_open_grid();
    test_blocked_cells();
    test_enclosure();

    test_random_traffic(0, 0, 140, 30);
    test_random_traffic(58, 0, 140, 45);
    test_random_traffic(0, 58, 140, 55);
    // Start the maze from a clean map.
    for (int r = 0; r < GRID_DIM; r++)
      for (int c = 0; c < GRID_DIM; c++)
        if (occ_grid[r][c]) write_cell(r, c, 1'b0);
    test_long_path();
    test_random_traffic(24, 24, 140, 40);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
